// ===== sv/oat_pkg.sv =====
// ----------------------------------------------------------------------------
// oat_pkg: shared types for the ordered array table
// Word layouts for the request and response channels, operation and status
// codes, and the fixed field widths.
// ----------------------------------------------------------------------------
package oat_pkg;

    // Fixed field widths
    localparam int OP_W  = 3;
    localparam int POS_W = 4;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // capacity_in_use after reset
    localparam logic [LEN_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    // Request word
    typedef struct packed {
        t_op                     operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    // Response word
    typedef struct packed {
        t_status                 status;
        logic [POS_W-1:0]        found_position;
        logic signed [VAL_W-1:0] read_value;
        logic [LEN_W-1:0]        live_length;
    } t_rsp;

endpackage

// ===== sv/oat_ifs.sv =====
// ----------------------------------------------------------------------------
// oat_req_if / oat_rsp_if: valid/ready channels of the ordered array table
// A word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface oat_req_if import oat_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface oat_rsp_if import oat_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/oat_ram.sv =====
// ----------------------------------------------------------------------------
// oat_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module oat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Storage array and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/oat_regs.sv =====
// ----------------------------------------------------------------------------
// oat_regs: APB configuration register
// Holds capacity_in_use and hands the engine the effective entry limit.
// ----------------------------------------------------------------------------
module oat_regs import oat_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    output logic [LEN_W-1:0]         o_limit
);

    // Register index taken from the word address
    localparam logic REG_CAPACITY = 1'b0;

    // Largest limit the count can express, saturated at the built capacity
    localparam logic [LEN_W-1:0] LIMIT_MAX =
        LEN_W'((CAPACITY > (2**LEN_W - 1)) ? (2**LEN_W - 1) : CAPACITY);

    logic [LEN_W-1:0] r_cap;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);

    // capacity_in_use register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (w_wr) begin
            r_cap <= pwdata[LEN_W-1:0];
        end
    end

    // Read-back
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(PDATA_W-LEN_W){1'b0}}, r_cap}
                                                : '0;

    // Effective limit
    assign o_limit = (r_cap > LIMIT_MAX) ? LIMIT_MAX : r_cap;

endmodule

// ===== sv/oat_engine.sv =====
// ----------------------------------------------------------------------------
// oat_engine: operation sequencer of the ordered array table
// Decodes a request, walks the entry RAM one access per cycle for shifts
// and searches, keeps the live count and holds the response register.
// ----------------------------------------------------------------------------
module oat_engine import oat_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LEN_W-1:0]  i_limit,
    oat_req_if.sink           i_req,
    oat_rsp_if.source         o_rsp,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [VAL_W-1:0]  o_wr_data,
    output logic [AW-1:0]     o_rd_addr,
    input  logic [VAL_W-1:0]  i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_SEARCH,
        S_UP,
        S_PUT,
        S_DOWN,
        S_EMIT
    } t_state;

    t_state                  r_state, n_state;
    logic [LEN_W-1:0]        r_count, n_count;
    logic [LEN_W-1:0]        r_idx,   n_idx;
    logic                    r_chk,   n_chk;
    logic [LEN_W-1:0]        r_pos,   n_pos;
    logic signed [VAL_W-1:0] r_val,   n_val;
    t_rsp                    r_pend,  n_pend;
    t_rsp                    r_out,   n_out;
    logic                    r_ovalid, n_ovalid;

    logic [LEN_W-1:0]        w_pos;
    logic [LEN_W-1:0]        w_hit_idx;
    logic [LEN_W-1:0]        w_wr_idx;
    logic [LEN_W-1:0]        w_rd_idx;

    assign w_pos     = {1'b0, i_req.data.position};
    assign w_hit_idx = r_idx - 5'd1;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_out;

    assign o_wr_addr = w_wr_idx[AW-1:0];
    assign o_rd_addr = w_rd_idx[AW-1:0];

    // Next-state and RAM access decode
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_chk     = r_chk;
        n_pos     = r_pos;
        n_val     = r_val;
        n_pend    = r_pend;
        n_out     = r_out;
        n_ovalid  = r_ovalid;
        o_wr_en   = 1'b0;
        w_wr_idx  = r_idx;
        o_wr_data = r_val;
        w_rd_idx  = r_idx;

        // response taken
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_val   = i_req.data.value;
                    n_pos   = w_pos;
                    n_state = S_EMIT;
                    n_pend  = '{status: ST_OK, found_position: '0, read_value: '0,
                                live_length: r_count};
                    unique case (i_req.data.operation)
                        OP_APPEND: begin
                            if (r_count >= i_limit) begin
                                n_pend.status = ST_FULL;
                            end else begin
                                o_wr_en            = 1'b1;
                                w_wr_idx           = r_count;
                                o_wr_data          = i_req.data.value;
                                n_count            = r_count + 5'd1;
                                n_pend.live_length = r_count + 5'd1;
                            end
                        end
                        OP_INSERT: begin
                            if (r_count >= i_limit) begin
                                n_pend.status = ST_FULL;
                            end else if (w_pos > r_count) begin
                                n_pend.status = ST_RANGE;
                            end else if (w_pos == r_count) begin
                                // insert at the end: plain append
                                o_wr_en            = 1'b1;
                                w_wr_idx           = r_count;
                                o_wr_data          = i_req.data.value;
                                n_count            = r_count + 5'd1;
                                n_pend.live_length = r_count + 5'd1;
                            end else begin
                                w_rd_idx = r_count - 5'd1;
                                n_idx    = r_count - 5'd1;
                                n_state  = S_UP;
                            end
                        end
                        OP_DELETE: begin
                            if (w_pos >= r_count) begin
                                n_pend.status = ST_RANGE;
                            end else if (w_pos + 5'd1 == r_count) begin
                                // last entry: nothing to move
                                n_count            = r_count - 5'd1;
                                n_pend.live_length = r_count - 5'd1;
                            end else begin
                                w_rd_idx = w_pos + 5'd1;
                                n_idx    = w_pos + 5'd1;
                                n_state  = S_DOWN;
                            end
                        end
                        OP_SEARCH: begin
                            n_pend.status = ST_MISS;
                            w_rd_idx      = '0;
                            n_chk         = (r_count != '0);
                            n_idx         = 5'd1;
                            n_state       = S_SEARCH;
                        end
                        OP_READ: begin
                            if (w_pos >= r_count) begin
                                n_pend.status = ST_RANGE;
                            end else begin
                                w_rd_idx = w_pos;
                                n_state  = S_RDWAIT;
                            end
                        end
                        default: begin
                            n_pend.status = ST_RANGE;
                        end
                    endcase
                end
            end

            // read data arrives in the cycle after the address
            S_RDWAIT: begin
                n_pend.read_value = i_rd_data;
                n_state           = S_EMIT;
            end

            // compare the entry issued last cycle, issue the next
            S_SEARCH: begin
                if (r_chk && (i_rd_data == r_val)) begin
                    n_pend.status         = ST_OK;
                    n_pend.found_position = w_hit_idx[POS_W-1:0];
                    n_state               = S_EMIT;
                end else if (!r_chk) begin
                    n_state = S_EMIT;
                end else begin
                    w_rd_idx = r_idx;
                    n_chk    = (r_idx < r_count);
                    n_idx    = r_idx + 5'd1;
                end
            end

            // move entry idx up by one, walking down to the insert point
            S_UP: begin
                o_wr_en   = 1'b1;
                w_wr_idx  = r_idx + 5'd1;
                o_wr_data = i_rd_data;
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    w_rd_idx = r_idx - 5'd1;
                    n_idx    = r_idx - 5'd1;
                end
            end

            // drop the new word into the gap
            S_PUT: begin
                o_wr_en            = 1'b1;
                w_wr_idx           = r_pos;
                o_wr_data          = r_val;
                n_count            = r_count + 5'd1;
                n_pend.live_length = r_count + 5'd1;
                n_state            = S_EMIT;
            end

            // move entry idx down by one, walking up to the end
            S_DOWN: begin
                o_wr_en   = 1'b1;
                w_wr_idx  = r_idx - 5'd1;
                o_wr_data = i_rd_data;
                if (r_idx + 5'd1 < r_count) begin
                    w_rd_idx = r_idx + 5'd1;
                    n_idx    = r_idx + 5'd1;
                end else begin
                    n_count            = r_count - 5'd1;
                    n_pend.live_length = r_count - 5'd1;
                    n_state            = S_EMIT;
                end
            end

            // hand the result to the output register once it is free
            S_EMIT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_out    = r_pend;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_chk    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_chk    <= n_chk;
        end
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

endmodule

// ===== sv/ordered_array_table.sv =====
// ----------------------------------------------------------------------------
// ordered_array_table: bounded dense array with insert, delete and search
// Dense array of signed 32-bit entries in one RAM with a live length.
//
//   channel  dir   handshake        word
//   i_req    in    valid/ready      operation, position, value
//   o_rsp    out   valid/ready      status, found_position, read_value,
//                                   live_length
//   apb      in    psel/penable     capacity_in_use at byte address 0
//
// One request is handled at a time; a result sits in its own output
// register, so the next request is taken while it waits.
// Insert and delete move each entry behind the position by one, and search
// compares the entries in order until a hit or the end. The single RAM
// read and write ports set the shift and scan time. Reset is synchronous,
// active low; RAM needs none.
// ----------------------------------------------------------------------------
module ordered_array_table import oat_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    oat_req_if.sink             i_req,
    oat_rsp_if.source           o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    // The count never exceeds what live_length can express
    localparam int DEPTH = (CAPACITY < 2**LEN_W) ? CAPACITY : 2**LEN_W;
    localparam int AW    = $clog2(DEPTH);

    logic [LEN_W-1:0] w_limit;
    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [VAL_W-1:0] w_wr_data;
    logic [AW-1:0]    w_rd_addr;
    logic [VAL_W-1:0] w_rd_data;

    // Configuration register
    oat_regs #(
        .CAPACITY (CAPACITY)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (w_limit)
    );

    // Entry storage
    oat_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer
    oat_engine #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_limit   (w_limit),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data)
    );

endmodule
